// ----- rtl/dual_pedal_sensor_plausibility_assert.svh -----
// Assertion macros for the pedal plausibility block.
// Needs nothing else; included by the top level.
`ifndef DUAL_PEDAL_SENSOR_PLAUSIBILITY_ASSERT_SVH
`define DUAL_PEDAL_SENSOR_PLAUSIBILITY_ASSERT_SVH

// ante holds now -> cons holds in the same cycle
`define DPSP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpsp assertion failed");

// ante holds now -> cons holds in the next cycle
`define DPSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpsp assertion failed");

`endif

// ----- rtl/dpsp_pkg.sv -----
// Shared types and constants for the pedal plausibility block.
// No dependencies.
package dpsp_pkg;

  localparam int DIV_STAGES     = 4;
  localparam int BITS_PER_STAGE = 2;

  localparam logic [7:0] SCALE_FULL = 8'hFF;

  // configuration register indexes
  localparam logic [2:0] REG_S1_LOW   = 3'd0;
  localparam logic [2:0] REG_S1_HIGH  = 3'd1;
  localparam logic [2:0] REG_S2_LOW   = 3'd2;
  localparam logic [2:0] REG_S2_HIGH  = 3'd3;
  localparam logic [2:0] REG_SLOP     = 3'd4;
  localparam logic [2:0] REG_DEADZONE = 3'd5;
  localparam logic [2:0] REG_DISAGREE = 3'd6;

  // reset values
  localparam logic [7:0] RST_S1_LOW   = 8'h9E;
  localparam logic [7:0] RST_S1_HIGH  = 8'hE7;
  localparam logic [7:0] RST_S2_LOW   = 8'h6D;
  localparam logic [7:0] RST_S2_HIGH  = 8'hA1;
  localparam logic [7:0] RST_SLOP     = 8'd10;
  localparam logic [6:0] RST_DEADZONE = 7'd10;
  localparam logic [7:0] RST_DISAGREE = 8'd25; // 0xFF / 10

  typedef struct packed {
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] slop;
  } lane_cfg_t;

  typedef struct packed {
    logic       fault;
    logic [7:0] scaled;
  } lane_res_t;

  typedef struct packed {
    logic [6:0] deadzone;
    logic [7:0] disagree;
  } merge_cfg_t;

endpackage

// ----- rtl/dpsp_in_if.sv -----
// Input channel: one pair of raw pedal sensor samples per transaction.
// Needs no package.
interface dpsp_in_if #(parameter int SAMPLE_BITS = 10);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_one;
  logic [SAMPLE_BITS-1:0] sample_two;

  modport source (output valid, output sample_one, output sample_two, input ready);
  modport sink   (input valid, input sample_one, input sample_two, output ready);
endinterface

// ----- rtl/dpsp_out_if.sv -----
// Result channel: scaled pedal positions, fault flag and speed command.
// Needs no package.
interface dpsp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pedal_one;
  logic [7:0]  pedal_two;
  logic        fault;
  logic [11:0] motor_speed;

  modport source (output valid, output pedal_one, output pedal_two, output fault,
                  output motor_speed, input ready);
  modport sink   (input valid, input pedal_one, input pedal_two, input fault,
                  input motor_speed, output ready);
endinterface

// ----- rtl/dual_pedal_sensor_plausibility.sv -----
// Channel   Dir  Payload                                       Transaction
// in_ch     in   sample_one, sample_two                         valid & ready
// out_ch    out  pedal_one, pedal_two, fault, motor_speed       valid & ready
// cfg_*     in   cfg_idx, cfg_wdata                             cfg_we
//
// One pair per cycle while the output register is empty or taken; a result
// passes through the front check register, the 4-stage scaling divider
// (2 quotient bits per stage) and the merge output register.
// The whole pipeline advances when the output register is empty or taken;
// a stalled output holds every stage. Synchronous reset clears valid bits
// and loads the calibration defaults.
// Top level of the pedal sensor plausibility block; depends on dpsp_pkg,
// the channel interfaces, dpsp_lane, dpsp_merge and the assertion macros.
`include "dual_pedal_sensor_plausibility_assert.svh"

module dual_pedal_sensor_plausibility #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  dpsp_in_if.sink    in_ch,
  dpsp_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [2:0] cfg_idx,
  input  logic [7:0] cfg_wdata
);

  logic [7:0] s1_low_r, s1_high_r, s2_low_r, s2_high_r, slop_r, disagree_r;
  logic [6:0] deadzone_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_low_r   <= dpsp_pkg::RST_S1_LOW;
      s1_high_r  <= dpsp_pkg::RST_S1_HIGH;
      s2_low_r   <= dpsp_pkg::RST_S2_LOW;
      s2_high_r  <= dpsp_pkg::RST_S2_HIGH;
      slop_r     <= dpsp_pkg::RST_SLOP;
      deadzone_r <= dpsp_pkg::RST_DEADZONE;
      disagree_r <= dpsp_pkg::RST_DISAGREE;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        dpsp_pkg::REG_S1_LOW:   s1_low_r   <= cfg_wdata;
        dpsp_pkg::REG_S1_HIGH:  s1_high_r  <= cfg_wdata;
        dpsp_pkg::REG_S2_LOW:   s2_low_r   <= cfg_wdata;
        dpsp_pkg::REG_S2_HIGH:  s2_high_r  <= cfg_wdata;
        dpsp_pkg::REG_SLOP:     slop_r     <= cfg_wdata;
        dpsp_pkg::REG_DEADZONE: deadzone_r <= cfg_wdata[6:0];
        dpsp_pkg::REG_DISAGREE: disagree_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic                            adv;
  logic [dpsp_pkg::DIV_STAGES:0]   vld_r;
  logic                            out_valid_r;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[dpsp_pkg::DIV_STAGES-1:0], in_ch.valid};
      out_valid_r <= vld_r[dpsp_pkg::DIV_STAGES];
    end
  end

  dpsp_pkg::lane_cfg_t  cfg_one, cfg_two;
  dpsp_pkg::lane_res_t  res_one, res_two;
  dpsp_pkg::merge_cfg_t mcfg;

  assign cfg_one = '{lo: s1_low_r, hi: s1_high_r, slop: slop_r};
  assign cfg_two = '{lo: s2_low_r, hi: s2_high_r, slop: slop_r};
  assign mcfg    = '{deadzone: deadzone_r, disagree: disagree_r};

  dpsp_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_one (
    .clk    (clk),
    .adv    (adv),
    .sample (in_ch.sample_one),
    .cfg    (cfg_one),
    .res    (res_one)
  );

  dpsp_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_two (
    .clk    (clk),
    .adv    (adv),
    .sample (in_ch.sample_two),
    .cfg    (cfg_two),
    .res    (res_two)
  );

  dpsp_merge u_merge (
    .clk           (clk),
    .adv           (adv),
    .res_one       (res_one),
    .res_two       (res_two),
    .cfg           (mcfg),
    .pedal_one_r   (out_ch.pedal_one),
    .pedal_two_r   (out_ch.pedal_two),
    .fault_r       (out_ch.fault),
    .motor_speed_r (out_ch.motor_speed)
  );

  assign out_ch.valid = out_valid_r;

  // a faulted result carries no position or speed
  `DPSP_ASSERT_SAME(a_fault_zero, clk, rst_n, out_valid_r && out_ch.fault,
    out_ch.pedal_one == 8'h00 && out_ch.pedal_two == 8'h00 && out_ch.motor_speed == 12'h000)
  // speed command tracks pedal one
  `DPSP_ASSERT_SAME(a_speed, clk, rst_n, out_valid_r && !out_ch.fault,
    out_ch.motor_speed == ({1'b0, out_ch.pedal_one, 3'b000} + {4'h0, out_ch.pedal_one}))
  // an accepted transaction enters the first stage
  `DPSP_ASSERT_NEXT(a_enter, clk, rst_n, in_ch.valid && in_ch.ready, vld_r[0])
  // stalled pipeline keeps its occupancy
  `DPSP_ASSERT_NEXT(a_hold, clk, rst_n, !adv, $stable(vld_r) && out_valid_r)

endmodule

// ----- rtl/dpsp_lane.sv -----
// One sensor lane: range check, clamp and pipelined scaling divider.
// Depends on dpsp_pkg.
module dpsp_lane #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   adv,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  dpsp_pkg::lane_cfg_t    cfg,
  output dpsp_pkg::lane_res_t    res
);

  typedef struct packed {
    logic       fault;
    logic       zero;
    logic [7:0] span;
    logic [7:0] rem;
    logic [7:0] nlo;
    logic [7:0] q;
  } div_st_t;

  // restoring division, BITS_PER_STAGE quotient bits
  function automatic div_st_t div_step(input div_st_t s);
    div_st_t    o;
    logic [8:0] t;
    o = s;
    for (int i = 0; i < dpsp_pkg::BITS_PER_STAGE; i++) begin
      t     = {o.rem, o.nlo[7]};
      o.nlo = {o.nlo[6:0], 1'b0};
      if (t >= {1'b0, o.span}) begin
        t   = t - {1'b0, o.span};
        o.q = {o.q[6:0], 1'b1};
      end else begin
        o.q = {o.q[6:0], 1'b0};
      end
      o.rem = t[7:0];
    end
    return o;
  endfunction

  logic [7:0]  v, x1, x2, dx;
  logic        f_hi, f_lo, f_span;
  logic [15:0] num;
  div_st_t     front;
  div_st_t     st_r [0:dpsp_pkg::DIV_STAGES];

  always_comb begin
    v    = sample[SAMPLE_BITS-1 -: 8];
    f_hi = (v > cfg.hi) && ({1'b0, v} > ({1'b0, cfg.hi} + {1'b0, cfg.slop}));
    x1   = (v > cfg.hi) ? cfg.hi : v;
    f_lo = (x1 < cfg.lo) && (({1'b0, x1} + {1'b0, cfg.slop}) < {1'b0, cfg.lo});
    x2   = (x1 < cfg.lo) ? cfg.lo : x1;
    f_span = (cfg.hi == cfg.lo);
    dx   = x2 - cfg.lo;
    num  = {dx, 8'h00} - {8'h00, dx}; // dx * 255
    front.fault = f_hi | f_lo | f_span;
    front.zero  = (cfg.hi < cfg.lo) || (x2 <= cfg.lo);
    front.span  = cfg.hi - cfg.lo;
    front.rem   = num[15:8];
    front.nlo   = num[7:0];
    front.q     = 8'h00;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= front;
    end
  end

  for (genvar k = 0; k < dpsp_pkg::DIV_STAGES; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[k+1] <= div_step(st_r[k]);
      end
    end
  end

  assign res.fault  = st_r[dpsp_pkg::DIV_STAGES].fault;
  assign res.scaled = st_r[dpsp_pkg::DIV_STAGES].zero ? 8'h00
                                                      : st_r[dpsp_pkg::DIV_STAGES].q;

endmodule

// ----- rtl/dpsp_merge.sv -----
// Merge stage: agreement check, deadzone, speed command, output register.
// Depends on dpsp_pkg.
module dpsp_merge (
  input  logic                 clk,
  input  logic                 adv,
  input  dpsp_pkg::lane_res_t  res_one,
  input  dpsp_pkg::lane_res_t  res_two,
  input  dpsp_pkg::merge_cfg_t cfg,
  output logic [7:0]           pedal_one_r,
  output logic [7:0]           pedal_two_r,
  output logic                 fault_r,
  output logic [11:0]          motor_speed_r
);

  function automatic logic [7:0] deadzone(input logic [7:0] m, input logic [6:0] dz);
    logic [7:0] top;
    top = dpsp_pkg::SCALE_FULL - {1'b0, dz};
    if (m < {1'b0, dz}) begin
      return 8'h00;
    end else if (m > top) begin
      return dpsp_pkg::SCALE_FULL;
    end
    return m;
  endfunction

  logic [7:0]  diff, m1, m2;
  logic        flt;
  logic [7:0]  pedal_one_nxt, pedal_two_nxt;
  logic [11:0] motor_speed_nxt;

  always_comb begin
    diff = (res_one.scaled > res_two.scaled) ? res_one.scaled - res_two.scaled
                                             : res_two.scaled - res_one.scaled;
    flt  = res_one.fault | res_two.fault | ((diff != 8'h00) && (diff >= cfg.disagree));
    m1   = deadzone(res_one.scaled, cfg.deadzone);
    m2   = deadzone(res_two.scaled, cfg.deadzone);
    pedal_one_nxt   = flt ? 8'h00 : m1;
    pedal_two_nxt   = flt ? 8'h00 : m2;
    motor_speed_nxt = flt ? 12'h000 : ({1'b0, m1, 3'b000} + {4'h0, m1});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pedal_one_r   <= pedal_one_nxt;
      pedal_two_r   <= pedal_two_nxt;
      fault_r       <= flt;
      motor_speed_r <= motor_speed_nxt;
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for dual_pedal_sensor_plausibility: sample-pair stimulus and
// calibration writes, every result checked against a built-in prediction.
// Needs dpsp_pkg, dpsp_in_if, dpsp_out_if and the block's RTL.
module tb_top;

  localparam int SAMPLE_BITS = 10;
  localparam int PIPE_CYCLES = 6;
  localparam int STUCK_LIMIT = 2000;
  localparam int RANDOM_SETTINGS = 11;
  localparam int ITEMS_PER_SETTING = 100;
  localparam int RX_HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0]  pedal_one;
    logic [7:0]  pedal_two;
    logic        fault;
    logic [11:0] motor_speed;
  } pedal_result_t;

  typedef struct packed {
    logic [7:0] s1_low;
    logic [7:0] s1_high;
    logic [7:0] s2_low;
    logic [7:0] s2_high;
    logic [7:0] slop;
    logic [6:0] deadzone;
    logic [7:0] disagree;
  } pedal_cal_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [2:0] cfg_idx;
  logic [7:0] cfg_wdata;

  dpsp_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  dpsp_out_if out_ch ();

  dual_pedal_sensor_plausibility #(.SAMPLE_BITS(SAMPLE_BITS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  pedal_cal_t    cal;
  pedal_result_t predicted_pedals[$];
  int            mismatches;
  int            pairs_sent;
  int            results_seen;
  int            fault_results;
  int            settings_applied;
  int            stuck_cycles;
  int            rx_hold_requests;
  bit            tx_idle;
  bit            rx_idle;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 70);
  endfunction

  function automatic pedal_cal_t reset_cal();
    pedal_cal_t c;
    c.s1_low   = dpsp_pkg::RST_S1_LOW;
    c.s1_high  = dpsp_pkg::RST_S1_HIGH;
    c.s2_low   = dpsp_pkg::RST_S2_LOW;
    c.s2_high  = dpsp_pkg::RST_S2_HIGH;
    c.slop     = dpsp_pkg::RST_SLOP;
    c.deadzone = dpsp_pkg::RST_DEADZONE;
    c.disagree = dpsp_pkg::RST_DISAGREE;
    return c;
  endfunction

  // ---------------------------------------------------------------- prediction

  // clamp, range check and scale one reading; 0 on a fault
  function automatic bit lane_position(input int rd, input int lo, input int hi,
                                       input int slop, output int pos);
    int x;
    int span;
    x   = rd;
    pos = 0;
    if (x > hi) begin
      if (x > hi + slop) return 1'b0;
      x = hi;
    end
    if (x < lo) begin
      if (x < lo - slop) return 1'b0;
      x = lo;
    end
    span = hi - lo;
    if (span == 0) return 1'b0;
    if (span < 0 || x <= lo) return 1'b1;
    pos = ((x - lo) * 255 / span) & 255;
    return 1'b1;
  endfunction

  function automatic int snap_ends(int m);
    if (m < int'(cal.deadzone)) return 0;
    if (m > 255 - int'(cal.deadzone)) return 255;
    return m;
  endfunction

  function automatic pedal_result_t compute_pedal_result(logic [SAMPLE_BITS-1:0] s1,
                                                         logic [SAMPLE_BITS-1:0] s2);
    pedal_result_t r;
    int            m1;
    int            m2;
    int            diff;
    bit            ok;
    r  = '0;
    ok = lane_position(int'(s1 >> (SAMPLE_BITS - 8)) & 255, cal.s1_low, cal.s1_high,
                       cal.slop, m1);
    if (!lane_position(int'(s2 >> (SAMPLE_BITS - 8)) & 255, cal.s2_low, cal.s2_high,
                       cal.slop, m2))
      ok = 1'b0;
    if (ok) begin
      diff = (m1 > m2) ? m1 - m2 : m2 - m1;
      // equal positions always agree, even with a zero limit
      if (diff != 0 && diff >= int'(cal.disagree)) ok = 1'b0;
    end
    if (!ok) begin
      r.fault = 1'b1;
    end else begin
      m1 = snap_ends(m1);
      m2 = snap_ends(m2);
      r.pedal_one   = 8'(m1);
      r.pedal_two   = 8'(m2);
      r.motor_speed = 12'(m1 * 9);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_pair(logic [SAMPLE_BITS-1:0] s1, logic [SAMPLE_BITS-1:0] s2);
    int gap;
    gap = tx_idle ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.sample_one = s1;
    in_ch.sample_two = s2;
    do @(posedge clk); while (!in_ch.ready);
    predicted_pedals.push_back(compute_pedal_result(s1, s2));
    pairs_sent++;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] to_sample(int rd);
    logic [SAMPLE_BITS-1:0] s;
    s = SAMPLE_BITS'(rd & 255) << (SAMPLE_BITS - 8);
    s = s | SAMPLE_BITS'($urandom_range(0, (1 << (SAMPLE_BITS - 8)) - 1));
    return s;
  endfunction

  task automatic send_reading(int rd1, int rd2);
    send_pair(to_sample(rd1), to_sample(rd2));
  endtask

  // sender holds off until every outstanding transaction has come back
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (predicted_pedals.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [7:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic apply_cal(pedal_cal_t c);
    wait_drained();
    write_cfg(dpsp_pkg::REG_S1_LOW,   c.s1_low);
    write_cfg(dpsp_pkg::REG_S1_HIGH,  c.s1_high);
    write_cfg(dpsp_pkg::REG_S2_LOW,   c.s2_low);
    write_cfg(dpsp_pkg::REG_S2_HIGH,  c.s2_high);
    write_cfg(dpsp_pkg::REG_SLOP,     c.slop);
    // top bit of the write data is outside the register
    write_cfg(dpsp_pkg::REG_DEADZONE, {1'($urandom_range(0, 1)), c.deadzone});
    write_cfg(dpsp_pkg::REG_DISAGREE, c.disagree);
    cal = c;
    settings_applied++;
  endtask

  // a change of rx_hold_requests starts one long hold-off
  initial begin : result_ready_driver
    int stall_left;
    int hold_left;
    int holds_seen;
    stall_left    = 0;
    hold_left     = 0;
    holds_seen    = 0;
    out_ch.ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_requests != holds_seen) begin
        holds_seen = rx_hold_requests;
        hold_left  = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
        if (rx_idle) stall_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin : result_check
    pedal_result_t got;
    pedal_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{pedal_one: out_ch.pedal_one, pedal_two: out_ch.pedal_two,
              fault: out_ch.fault, motor_speed: out_ch.motor_speed};
      results_seen++;
      if (got.fault) fault_results++;
      if (predicted_pedals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result p1=%0d p2=%0d fault=%0b speed=%0d",
                   $time, got.pedal_one, got.pedal_two, got.fault, got.motor_speed);
      end else begin
        want = predicted_pedals.pop_front();
        if (got.pedal_one !== want.pedal_one || got.pedal_two !== want.pedal_two ||
            got.fault !== want.fault || got.motor_speed !== want.motor_speed) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: result %0d want p1=%0d p2=%0d fault=%0b speed=%0d,",
                      " got p1=%0d p2=%0d fault=%0b speed=%0d"},
                     $time, results_seen, want.pedal_one, want.pedal_two, want.fault,
                     want.motor_speed, got.pedal_one, got.pedal_two, got.fault,
                     got.motor_speed);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
      $display("dual_pedal_sensor_plausibility: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus helpers

  function automatic int biased(int maxv, int typ);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return maxv;
    if (r == 2) return $urandom_range(1, 3);
    return $urandom_range(0, typ);
  endfunction

  function automatic int clamp_reading(int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  // reading of a sensor at pedal travel p (0..255), with a little noise
  function automatic int near_position(int lo, int hi, int p);
    return clamp_reading(lo + (clamp_reading(p) * (hi - lo)) / 255
                         + int'($urandom_range(0, 4)) - 2);
  endfunction

  function automatic int bound_probe(int lo, int hi);
    case ($urandom_range(0, 5))
      0:       return clamp_reading(hi + int'(cal.slop));
      1:       return clamp_reading(hi + int'(cal.slop) + 1);
      2:       return clamp_reading(lo - int'(cal.slop));
      3:       return clamp_reading(lo - int'(cal.slop) - 1);
      4:       return hi;
      default: return lo;
    endcase
  endfunction

  task automatic random_span(output logic [7:0] lo, output logic [7:0] hi);
    int a;
    int b;
    int r;
    a = $urandom_range(0, 255);
    b = $urandom_range(0, 255);
    r = $urandom_range(0, 19);
    if (r == 0) b = a;                 // zero span
    else if (r > 2 && a > b) begin     // mostly ordered, sometimes inverted
      a = a ^ b; b = a ^ b; a = a ^ b;
    end
    lo = 8'(a);
    hi = 8'(b);
  endtask

  task automatic random_cal(output pedal_cal_t c);
    random_span(c.s1_low, c.s1_high);
    random_span(c.s2_low, c.s2_high);
    c.slop     = 8'(biased(255, 30));
    c.deadzone = 7'(biased(127, 30));
    c.disagree = 8'(biased(255, 80));
  endtask

  task automatic run_random_pairs(int count);
    int p;
    int skew;
    int r;
    int rd1;
    int rd2;
    for (int i = 0; i < count; i++) begin
      r    = $urandom_range(0, 99);
      p    = $urandom_range(0, 255);
      skew = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 80)) - 40
                                         : int'($urandom_range(0, 6)) - 3;
      rd1  = near_position(cal.s1_low, cal.s1_high, p);
      rd2  = near_position(cal.s2_low, cal.s2_high, p + skew);
      if (r < 75) begin
        send_reading(rd1, rd2);
      end else if (r < 88) begin
        if ($urandom_range(0, 1))
          send_reading(bound_probe(cal.s1_low, cal.s1_high), rd2);
        else
          send_reading(rd1, bound_probe(cal.s2_low, cal.s2_high));
      end else begin
        send_pair(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------- tests

  // runs on the reset calibration, before any register write
  task automatic test_field_extremes();
    send_pair('0, '0);
    send_pair('1, '1);
    send_pair('0, '1);
    send_pair('1, '0);
    send_reading(158, 109);
  endtask

  task automatic test_default_calibration();
    send_reading(231, 161);   // both fully pressed
    send_reading(236, 165);   // overshoot within margin, clamped
    send_reading(242, 161);   // overshoot past margin
    send_reading(148, 99);    // undershoot exactly at margin
    send_reading(147, 109);   // undershoot past margin
    send_reading(194, 135);   // mid travel, agreeing
    send_reading(194, 161);   // sensors disagree
    send_reading(160, 111);   // lower deadzone
    send_reading(229, 159);   // upper deadzone on one side only
  endtask

  task automatic test_span_and_inversion();
    apply_cal('{s1_low: 100, s1_high: 100, s2_low: 0, s2_high: 255,
                slop: 10, deadzone: 10, disagree: 25});
    send_reading(100, 0);
    apply_cal('{s1_low: 200, s1_high: 50, s2_low: 0, s2_high: 255,
                slop: 255, deadzone: 0, disagree: 25});
    send_reading(120, 0);
    send_reading(255, 3);
    // low bound minus margin goes below zero
    apply_cal('{s1_low: 10, s1_high: 250, s2_low: 5, s2_high: 250,
                slop: 20, deadzone: 0, disagree: 25});
    send_reading(0, 0);
  endtask

  task automatic test_agreement_and_deadzone();
    apply_cal('{s1_low: 0, s1_high: 255, s2_low: 0, s2_high: 255,
                slop: 0, deadzone: 0, disagree: 0});
    send_reading(100, 100);
    send_reading(100, 101);
    apply_cal('{s1_low: 0, s1_high: 255, s2_low: 0, s2_high: 255,
                slop: 0, deadzone: 0, disagree: 255});
    send_reading(255, 0);
    send_reading(254, 0);
    apply_cal('{s1_low: 0, s1_high: 255, s2_low: 0, s2_high: 255,
                slop: 0, deadzone: 127, disagree: 255});
    send_reading(126, 126);
    send_reading(129, 129);
    send_reading(128, 128);
  endtask

  // receiver blocks for a long stretch while the sender keeps offering
  task automatic test_output_backpressure();
    apply_cal(reset_cal());
    tx_idle = 1'b0;
    rx_hold_requests++;
    run_random_pairs(40);
    wait_drained();
    tx_idle = 1'b1;
  endtask

  task automatic test_random_calibrations();
    pedal_cal_t c;
    for (int ph = 0; ph < RANDOM_SETTINGS; ph++) begin
      case (ph)
        0: c = reset_cal();
        1: c = '{s1_low: 0, s1_high: 255, s2_low: 0, s2_high: 255,
                 slop: 0, deadzone: 0, disagree: 255};
        2: c = '{s1_low: 0, s1_high: 255, s2_low: 0, s2_high: 255,
                 slop: 255, deadzone: 127, disagree: 0};
        default: random_cal(c);
      endcase
      apply_cal(c);
      // one setting runs at full rate on both sides
      tx_idle = (ph != 3);
      rx_idle = (ph != 3);
      run_random_pairs(ITEMS_PER_SETTING);
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.sample_one = '0;
    in_ch.sample_two = '0;
    mismatches       = 0;
    pairs_sent       = 0;
    results_seen     = 0;
    fault_results    = 0;
    settings_applied = 0;
    rx_hold_requests = 0;
    tx_idle          = 1'b1;
    rx_idle          = 1'b1;
    cal              = reset_cal();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_field_extremes();
    test_default_calibration();
    test_span_and_inversion();
    test_agreement_and_deadzone();
    test_output_backpressure();
    test_random_calibrations();

    wait_drained();
    repeat (PIPE_CYCLES * 2) @(posedge clk);
    $display("Run covered %0d sample pairs under %0d calibration settings,",
             pairs_sent, settings_applied + 1);
    $display("  %0d results checked (%0d faulted), %0d mismatches.",
             results_seen, fault_results, mismatches);
    if (mismatches == 0 && predicted_pedals.size() == 0)
      $display("dual_pedal_sensor_plausibility: match");
    else
      $display("dual_pedal_sensor_plausibility: mismatch");
    $finish;
  end

endmodule
